### hw/rtl/pip_pkg.sv
package pip_pkg;

    // Width of the vertex count register and of the load slot field.
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned SLOT_W = 4;

    // Vertex count after reset.
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);

    // Operation carried by an input word.
    typedef enum logic [0:0] {
        FUNC_LOAD = 1'b0,
        FUNC_TEST = 1'b1
    } func_t;

    // Control that travels with every word down the cell chain.
    typedef struct packed {
        logic valid;
        logic test;
        logic parity;
    } pip_ctl_t;

endpackage

### hw/rtl/pip_in_if.sv
interface pip_in_if #(
    parameter int unsigned COORD_WIDTH = 12
);
    logic                                   valid;
    logic                                   ready;
    logic [0:0]                             func;
    logic [pip_pkg::SLOT_W-1:0]             slot;
    logic signed [COORD_WIDTH-1:0]          coord_x;
    logic signed [COORD_WIDTH-1:0]          coord_y;

    modport source (output valid, output func, output slot, output coord_x, output coord_y,
                    input ready);
    modport sink   (input valid, input func, input slot, input coord_x, input coord_y,
                    output ready);
endinterface

### hw/rtl/pip_out_if.sv
interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

### hw/rtl/point_in_polygon_test.sv
// A test word travels through the registers of every vertex cell, then the closing-edge and output registers.
// Throughput: one word (load or test) per cycle unless stalled; the vertex cell chain is fully pipelined.
// The input stalls only while both the output register and the skid entry behind it are full.
// Reset (rst_n, asynchronous, active low) empties the chain and output and sets the vertex
// count to 3; vertex contents are undefined until loaded.
module point_in_polygon_test #(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned COORD_WIDTH  = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pip_pkg::CNT_W-1:0]   cfg_data,
    pip_in_if.sink                      item,
    pip_out_if.source                   result
);
    import pip_pkg::*;

    localparam int unsigned CW = COORD_WIDTH;
    localparam int unsigned N  = MAX_VERTICES;

    // Vertex count register. Write it only while the block is idle; the block itself does not enforce this.
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_RESET;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    // The whole chain moves together. It holds only while the skid entry is occupied,
    // which depends on registers alone, so the input ready never waits on the output ready.
    logic adv;
    logic skid_valid_reg, skid_valid_next;
    logic skid_res_reg, skid_res_next;
    logic out_valid_reg, out_valid_next;
    logic out_res_reg, out_res_next;

    assign adv        = !skid_valid_reg;
    assign item.ready = adv;

    // Word links between cells. Link 0 is the input port, link k is the output of cell k-1.
    // Each word carries the test point (or the vertex being loaded), the previous active
    // vertex, the first vertex and the running crossing parity.
    pip_ctl_t             ctl_l  [0:N];
    logic [SLOT_W-1:0]    slot_l [0:N];
    logic signed [CW-1:0] px_l   [0:N];
    logic signed [CW-1:0] py_l   [0:N];
    logic signed [CW-1:0] ox_l   [0:N];
    logic signed [CW-1:0] oy_l   [0:N];
    logic signed [CW-1:0] fx_l   [0:N];
    logic signed [CW-1:0] fy_l   [0:N];

    always_comb
    begin
        ctl_l[0].valid  = item.valid;
        ctl_l[0].test   = (item.func == FUNC_TEST);
        ctl_l[0].parity = 1'b0;
        slot_l[0]       = item.slot;
        px_l[0]         = item.coord_x;
        py_l[0]         = item.coord_y;
        ox_l[0]         = item.coord_x;
        oy_l[0]         = item.coord_y;
        fx_l[0]         = item.coord_x;
        fy_l[0]         = item.coord_y;
    end

    // Cell k stores vertex k. An active cell other than the first checks the edge from the
    // previous active vertex to its own; the first cell only seeds the previous and first
    // vertex fields. Cells at or above the count pass words on unchanged, but cell 0 still sets the first vertex field.
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        pip_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .count    (count_reg),
            .in_ctl   (ctl_l[k]),
            .in_slot  (slot_l[k]),
            .in_px    (px_l[k]),
            .in_py    (py_l[k]),
            .in_ox    (ox_l[k]),
            .in_oy    (oy_l[k]),
            .in_fx    (fx_l[k]),
            .in_fy    (fy_l[k]),
            .out_ctl  (ctl_l[k+1]),
            .out_slot (slot_l[k+1]),
            .out_px   (px_l[k+1]),
            .out_py   (py_l[k+1]),
            .out_ox   (ox_l[k+1]),
            .out_oy   (oy_l[k+1]),
            .out_fx   (fx_l[k+1]),
            .out_fy   (fy_l[k+1])
        );
    end

    // Closing edge from the last active vertex back to vertex 0. With a count of zero there
    // are no edges at all, so it is switched off. A single vertex gives a zero-width edge,
    // which never toggles.
    logic     close_en, close_toggle;
    pip_ctl_t cls_ctl_reg;
    logic     emit, res_bit, out_take;

    assign close_en = ctl_l[N].valid && ctl_l[N].test && (count_reg != '0);

    pip_edge #(
        .CW (CW)
    ) u_close (
        .clk    (clk),
        .adv    (adv),
        .en     (close_en),
        .ax     (ox_l[N]),
        .ay     (oy_l[N]),
        .bx     (fx_l[N]),
        .by     (fy_l[N]),
        .px     (px_l[N]),
        .py     (py_l[N]),
        .toggle (close_toggle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_ctl_reg <= '0;
        end
        else if (adv)
        begin
            cls_ctl_reg <= ctl_l[N];
        end
    end

    // Load words end here without a result; test words deliver their final parity.
    assign emit     = adv && cls_ctl_reg.valid && cls_ctl_reg.test;
    assign res_bit  = cls_ctl_reg.parity ^ close_toggle;
    assign out_take = out_valid_reg && result.ready;

    // Output register with one skid entry behind it. A result that arrives while the
    // output word is stalled parks in the skid entry and moves up once the output is taken.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_res_next   = res_bit;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_res_next   = res_bit;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = out_res_reg;

    // The skid entry is only ever filled behind a waiting output word.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a word while the output register is empty");

    // The skid entry fills only when a result meets a stalled output word.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result.ready))
        else $error("skid entry filled while the output was free");

    // The skid entry drains only when the output word is taken.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(skid_valid_reg) |-> $past(result.ready))
        else $error("skid entry drained without an output transfer");

endmodule

### hw/rtl/pip_edge.sv
module pip_edge #(
    parameter int unsigned CW = 12
) (
    input  logic                 clk,
    input  logic                 adv,
    input  logic                 en,
    input  logic signed [CW-1:0] ax,
    input  logic signed [CW-1:0] ay,
    input  logic signed [CW-1:0] bx,
    input  logic signed [CW-1:0] by,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    output logic                 toggle
);
    localparam int unsigned DW = CW + 1;
    localparam int unsigned PW = 2 * DW;

    logic signed [CW-1:0] x1, y1, x2, y2;
    logic                 hit_next, hit_reg;
    logic signed [DW-1:0] dx_next, dy_next, qx_next, qy_next;
    logic signed [DW-1:0] dx_reg, dy_reg, qx_reg, qy_reg;
    logic signed [PW-1:0] lhs, rhs;

    // First step: order the endpoints by x, check the span, form the differences.
    always_comb
    begin
        if (bx > ax)
        begin
            x1 = ax;
            y1 = ay;
            x2 = bx;
            y2 = by;
        end
        else
        begin
            x1 = bx;
            y1 = by;
            x2 = ax;
            y2 = ay;
        end
        hit_next = en && (x1 < px) && (px <= x2);
        dx_next  = DW'(x2) - DW'(x1);
        dy_next  = DW'(y2) - DW'(y1);
        qx_next  = DW'(px) - DW'(x1);
        qy_next  = DW'(py) - DW'(y1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
        end
    end

    // Second step: exact cross-multiplied test of the point against the edge.
    always_comb
    begin
        lhs    = PW'(qy_reg) * PW'(dx_reg);
        rhs    = PW'(dy_reg) * PW'(qx_reg);
        toggle = hit_reg && (lhs < rhs);
    end

endmodule

### hw/rtl/pip_cell.sv
module pip_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic [pip_pkg::CNT_W-1:0]      count,
    input  pip_pkg::pip_ctl_t              in_ctl,
    input  logic [pip_pkg::SLOT_W-1:0]     in_slot,
    input  logic signed [CW-1:0]           in_px,
    input  logic signed [CW-1:0]           in_py,
    input  logic signed [CW-1:0]           in_ox,
    input  logic signed [CW-1:0]           in_oy,
    input  logic signed [CW-1:0]           in_fx,
    input  logic signed [CW-1:0]           in_fy,
    output pip_pkg::pip_ctl_t              out_ctl,
    output logic [pip_pkg::SLOT_W-1:0]     out_slot,
    output logic signed [CW-1:0]           out_px,
    output logic signed [CW-1:0]           out_py,
    output logic signed [CW-1:0]           out_ox,
    output logic signed [CW-1:0]           out_oy,
    output logic signed [CW-1:0]           out_fx,
    output logic signed [CW-1:0]           out_fy
);
    import pip_pkg::*;

    localparam bit SLOT_FITS = (IDX < (2 ** SLOT_W));
    localparam bit IS_FIRST  = (IDX == 0);

    logic signed [CW-1:0] vx_reg, vy_reg;
    logic                 active, load_hit, edge_en, toggle;

    pip_ctl_t             ctl1_reg, ctl2_reg, ctl2_next;
    logic [SLOT_W-1:0]    slot1_reg, slot2_reg;
    logic signed [CW-1:0] px1_reg, py1_reg, ox1_reg, oy1_reg, fx1_reg, fy1_reg;
    logic signed [CW-1:0] px2_reg, py2_reg, ox2_reg, oy2_reg, fx2_reg, fy2_reg;
    logic signed [CW-1:0] ox1_next, oy1_next, fx1_next, fy1_next;

    always_comb
    begin
        active   = (32'(count) > IDX);
        load_hit = in_ctl.valid && (in_ctl.test == FUNC_LOAD) && SLOT_FITS
                   && (in_slot == SLOT_W'(IDX));
        edge_en  = in_ctl.valid && (in_ctl.test == FUNC_TEST) && active && !IS_FIRST;
        ox1_next = active ? vx_reg : in_ox;
        oy1_next = active ? vy_reg : in_oy;
        fx1_next = IS_FIRST ? vx_reg : in_fx;
        fy1_next = IS_FIRST ? vy_reg : in_fy;
    end

    // A load word writes this cell's vertex as it passes, so words behind it see the new value.
    always_ff @(posedge clk)
    begin
        if (adv && load_hit)
        begin
            vx_reg <= in_px;
            vy_reg <= in_py;
        end
    end

    pip_edge #(
        .CW (CW)
    ) u_edge (
        .clk    (clk),
        .adv    (adv),
        .en     (edge_en),
        .ax     (in_ox),
        .ay     (in_oy),
        .bx     (vx_reg),
        .by     (vy_reg),
        .px     (in_px),
        .py     (in_py),
        .toggle (toggle)
    );

    always_comb
    begin
        ctl2_next        = ctl1_reg;
        ctl2_next.parity = ctl1_reg.parity ^ toggle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            slot1_reg <= in_slot;
            px1_reg   <= in_px;
            py1_reg   <= in_py;
            ox1_reg   <= ox1_next;
            oy1_reg   <= oy1_next;
            fx1_reg   <= fx1_next;
            fy1_reg   <= fy1_next;
            slot2_reg <= slot1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            ox2_reg   <= ox1_reg;
            oy2_reg   <= oy1_reg;
            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
        end
    end

    assign out_ctl  = ctl2_reg;
    assign out_slot = slot2_reg;
    assign out_px   = px2_reg;
    assign out_py   = py2_reg;
    assign out_ox   = ox2_reg;
    assign out_oy   = oy2_reg;
    assign out_fx   = fx2_reg;
    assign out_fy   = fy2_reg;

endmodule
